/* sv/rtsenc_pkg.sv */
`timescale 1ns / 1ps
// rtsenc_pkg: shared types, codes, line layout constants and line bit/byte functions for the remote frame encoder
// depends on nothing
package rtsenc_pkg;

  localparam int unsigned FRAME_LEN = 7;
  localparam int unsigned DATA_BITS = 56;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] code_t;
  typedef logic [23:0] addr_t;
  typedef logic [DATA_BITS-1:0] frame_t;
  typedef logic [5:0]  byte_idx_t;
  typedef logic [8:0]  bit_pos_t;
  typedef logic [1:0]  reg_idx_t;

  localparam logic MODE_BUILD  = 1'b0;
  localparam logic MODE_REPEAT = 1'b1;

  localparam reg_idx_t REG_ADDR = 2'd0;
  localparam reg_idx_t REG_CODE = 2'd1;
  localparam reg_idx_t REG_KEY  = 2'd2;

  localparam byte_t KEY_RESET = 8'hA7;

  // build transmission: 16 ones, 148 zeros, 2 syncs, 8 ones, 112 data bits, 44 zeros
  localparam bit_pos_t WAKE_END  = 9'd16;
  localparam bit_pos_t B_SYNC    = 9'd164;
  localparam bit_pos_t B_ONES    = 9'd180;
  localparam bit_pos_t B_DATA    = 9'd188;
  localparam bit_pos_t B_TAIL    = 9'd300;
  localparam byte_idx_t B_BYTES  = 6'd43;

  // repeat transmission: 7 syncs, 8 ones, 112 data bits, 48 zeros
  localparam bit_pos_t R_SYNC    = 9'd0;
  localparam bit_pos_t R_ONES    = 9'd56;
  localparam bit_pos_t R_DATA    = 9'd64;
  localparam bit_pos_t R_TAIL    = 9'd176;
  localparam byte_idx_t R_BYTES  = 6'd28;

  function automatic logic line_bit(input logic mode, input bit_pos_t pos, input frame_t frame);
    bit_pos_t sync_start;
    bit_pos_t ones_start;
    bit_pos_t data_start;
    bit_pos_t tail_start;
    bit_pos_t rel_sync;
    bit_pos_t rel_data;
    logic [5:0] di;
    logic b;
    logic r;
    begin
      if (mode == MODE_BUILD) begin
        sync_start = B_SYNC;
        ones_start = B_ONES;
        data_start = B_DATA;
        tail_start = B_TAIL;
      end else begin
        sync_start = R_SYNC;
        ones_start = R_ONES;
        data_start = R_DATA;
        tail_start = R_TAIL;
      end
      rel_sync = pos - sync_start;
      rel_data = pos - data_start;
      di = rel_data[6:1];
      b = frame[6'(DATA_BITS - 1) - di];
      if (mode == MODE_BUILD && pos < WAKE_END) begin
        r = 1'b1;
      end else if (pos < sync_start) begin
        r = 1'b0;
      end else if (pos < ones_start) begin
        r = ~rel_sync[2];
      end else if (pos < data_start) begin
        r = 1'b1;
      end else if (pos < tail_start) begin
        r = rel_data[0] ? b : ~b;
      end else begin
        r = 1'b0;
      end
      return r;
    end
  endfunction

  function automatic byte_t line_byte(input logic mode, input byte_idx_t idx, input frame_t frame);
    byte_t v;
    bit_pos_t base;
    begin
      base = {idx, 3'b000};
      for (int k = 0; k < 8; k++) begin
        v[7-k] = line_bit(mode, base + bit_pos_t'(k), frame);
      end
      return v;
    end
  endfunction

endpackage

/* sv/rtsenc_in_if.sv */
`timescale 1ns / 1ps
// rtsenc_in_if: command channel, valid/ready with mode and button payload
// depends on nothing
interface rtsenc_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [3:0] button;

  modport source (output valid, output mode, output button, input ready);
  modport sink   (input valid, input mode, input button, output ready);
endinterface

/* sv/rtsenc_out_if.sv */
`timescale 1ns / 1ps
// rtsenc_out_if: line byte channel, valid/ready with byte, last flag and code payload
// depends on nothing
interface rtsenc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  stream_byte;
  logic        last_byte;
  logic [15:0] code_used;

  modport source (output valid, output stream_byte, output last_byte, output code_used,
                  input ready);
  modport sink   (input valid, input stream_byte, input last_byte, input code_used,
                  output ready);
endinterface

/* sv/rts_remote_frame_encoder_core.sv */
`timescale 1ns / 1ps
// rts_remote_frame_encoder_core: rolling code frame builder and line byte serializer
// depends on rtsenc_pkg, rtsenc_in_if, rtsenc_out_if
//
// usage:
//   cmd carries one beat per transmission (mode, button). mode 0 builds a new
//   frame from key, button, rolling code and address, then sends 43 line bytes
//   with wake-up; mode 1 resends the stored frame as 28 line bytes.
//   stream carries one beat per line byte, earliest bit in the msb, last_byte
//   set on the final beat, code_used holding the code carried in the frame.
//   cfg_we/cfg_index/cfg_data write address (0), rolling code (1), key (2);
//   other indexes are ignored. write only while no transmission is running.
// timing:
//   mode 0: a load in IDLE, the nibble checksum in SUM and the byte chaining
//   in CHAIN, then one line byte per cycle while stream is not stalled.
//   mode 1: straight from IDLE to SEND, then its 28 bytes at the same rate.
//   cmd.ready is high only between transmissions; the next command can be taken
//   while the final byte still waits in the output register.
// reset: rolling code and stored frame clear, key returns to a7, output empties.
// stall: a held stream beat freezes the serializer until it is taken.
module rts_remote_frame_encoder_core (
  input  logic                 clk,
  input  logic                 rst,
  rtsenc_in_if.sink            cmd,
  rtsenc_out_if.source         stream,
  input  logic                 cfg_we,
  input  rtsenc_pkg::reg_idx_t cfg_index,
  input  rtsenc_pkg::addr_t    cfg_data
);
  import rtsenc_pkg::*;

  typedef enum logic [1:0] {IDLE, SUM, CHAIN, SEND} state_t;

  state_t    state;
  byte_t     f [FRAME_LEN];
  addr_t     remote_address;
  code_t     rolling_code;
  byte_t     key_byte;
  code_t     code_reg;
  logic      mode_reg;
  logic [2:0] cnt;
  logic [3:0] sum;
  logic [3:0] sum_next;
  byte_t     prev;
  byte_t     chained;
  byte_idx_t byte_idx;
  byte_idx_t nbytes;
  frame_t    frame;
  logic      out_valid;
  byte_t     out_byte;
  logic      out_last;
  code_t     out_code;

  assign frame    = {f[0], f[1], f[2], f[3], f[4], f[5], f[6]};
  assign nbytes   = (mode_reg == MODE_BUILD) ? B_BYTES : R_BYTES;
  assign sum_next = sum ^ f[cnt][7:4] ^ f[cnt][3:0];
  assign chained  = f[cnt] ^ prev;

  assign cmd.ready          = (state == IDLE);
  assign stream.valid       = out_valid;
  assign stream.stream_byte = out_byte;
  assign stream.last_byte   = out_last;
  assign stream.code_used   = out_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      remote_address <= '0;
      rolling_code   <= '0;
      key_byte       <= KEY_RESET;
      out_valid      <= 1'b0;
      for (int i = 0; i < FRAME_LEN; i++) begin
        f[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ADDR: remote_address <= cfg_data;
          REG_CODE: rolling_code   <= cfg_data[15:0];
          REG_KEY:  key_byte       <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_valid && stream.ready && state != SEND) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (cmd.valid) begin
            mode_reg <= cmd.mode;
            byte_idx <= '0;
            if (cmd.mode == MODE_BUILD) begin
              f[0]     <= key_byte;
              f[1]     <= {cmd.button, 4'b0000};
              f[2]     <= rolling_code[15:8];
              f[3]     <= rolling_code[7:0];
              f[4]     <= remote_address[23:16];
              f[5]     <= remote_address[15:8];
              f[6]     <= remote_address[7:0];
              code_reg <= rolling_code;
              sum      <= '0;
              cnt      <= '0;
              state    <= SUM;
            end else begin
              code_reg <= {f[2] ^ f[1], f[3] ^ f[2]};
              state    <= SEND;
            end
          end
        end
        SUM: begin
          sum <= sum_next;
          if (cnt == 3'(FRAME_LEN - 1)) begin
            f[1]  <= f[1] | {4'b0000, sum_next};
            prev  <= f[0];
            cnt   <= 3'd1;
            state <= CHAIN;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        CHAIN: begin
          f[cnt] <= chained;
          prev   <= chained;
          if (cnt == 3'(FRAME_LEN - 1)) begin
            rolling_code <= rolling_code + 16'd1;
            state        <= SEND;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        SEND: begin
          if (!out_valid || stream.ready) begin
            out_valid <= 1'b1;
            out_byte  <= line_byte(mode_reg, byte_idx, frame);
            out_last  <= (byte_idx == nbytes - 6'd1);
            out_code  <= code_reg;
            if (byte_idx == nbytes - 6'd1) begin
              state <= IDLE;
            end else begin
              byte_idx <= byte_idx + 6'd1;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // serializer never runs past the length of its transmission
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    state == SEND |-> byte_idx < nbytes)
    else $error("line byte index past end of transmission");

  // a build captures the code in use before it advances
  a_code_capture: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready && cmd.mode == MODE_BUILD |=> code_reg == $past(rolling_code))
    else $error("code_used does not match rolling code at build");

  // a stalled beat holds its payload until taken
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    stream.valid && !stream.ready |=> stream.valid && $stable(stream.stream_byte) &&
      $stable(stream.last_byte) && $stable(stream.code_used))
    else $error("stalled beat changed before it was taken");

  // a taken command closes the command channel
  a_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |=> !cmd.ready)
    else $error("command channel open while transmission runs");

endmodule

/* test/rts_remote_frame_encoder_core_tb.sv */
`timescale 1ns / 1ps
// rts_remote_frame_encoder_core_tb: checks every line byte of the remote frame encoder
// against a frame builder and serializer kept in the bench, under random gaps and stalls
// depends on rtsenc_pkg, rtsenc_in_if, rtsenc_out_if and rts_remote_frame_encoder_core
module rts_remote_frame_encoder_core_tb;
  import rtsenc_pkg::*;

  localparam reg_idx_t REG_UNUSED  = 2'd3;
  localparam int WAKE_ONES    = 16;
  localparam int SILENCE_BITS = 148;
  localparam int TAIL_ZEROS   = 51;
  localparam int BUILD_SYNCS  = 2;
  localparam int REPEAT_SYNCS = 7;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    byte_t data;
    logic  last;
    code_t code;
  } line_beat_t;

  logic     clk = 1'b0;
  logic     rst;
  logic     cfg_we;
  reg_idx_t cfg_index;
  addr_t    cfg_data;

  rtsenc_in_if  cmd_if ();
  rtsenc_out_if stream_if ();

  rts_remote_frame_encoder_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_if),
    .stream    (stream_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // bench copy of the block state
  addr_t remote_addr;
  code_t roll_code;
  byte_t key_val;
  byte_t held_frame [FRAME_LEN];

  line_beat_t line_beats_q [$];
  bit         line_bits [$];
  int         beat_errs;
  int         beats_seen;
  bit         quiet_cmd;
  bit         quiet_stream;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_wait(input bit quiet);
    return quiet ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic void add_run(input bit v, input int n);
    for (int i = 0; i < n; i++) line_bits.push_back(v);
  endfunction

  // builds or recalls the frame and queues every line byte of the transmission
  function automatic void encode_transmission(input logic mode, input logic [3:0] btn);
    byte_t      fr [FRAME_LEN];
    logic [3:0] nib;
    code_t      carried;
    int         nsyncs;
    int         nbytes;
    bit         b;
    byte_t      v;
    line_beat_t beat;
    line_bits.delete();
    if (mode == MODE_BUILD) begin
      carried = roll_code;
      fr[0] = key_val;
      fr[1] = {btn, 4'h0};
      fr[2] = roll_code[15:8];
      fr[3] = roll_code[7:0];
      fr[4] = remote_addr[23:16];
      fr[5] = remote_addr[15:8];
      fr[6] = remote_addr[7:0];
      nib = 4'h0;
      for (int i = 0; i < FRAME_LEN; i++) nib = nib ^ fr[i][7:4] ^ fr[i][3:0];
      fr[1] = fr[1] | {4'h0, nib};
      for (int i = 1; i < FRAME_LEN; i++) fr[i] = fr[i] ^ fr[i-1];
      for (int i = 0; i < FRAME_LEN; i++) held_frame[i] = fr[i];
      roll_code = roll_code + 16'd1;
      nsyncs = BUILD_SYNCS;
      add_run(1'b1, WAKE_ONES);
      add_run(1'b0, SILENCE_BITS);
    end else begin
      carried = {held_frame[2] ^ held_frame[1], held_frame[3] ^ held_frame[2]};
      nsyncs = REPEAT_SYNCS;
    end
    for (int i = 0; i < nsyncs; i++) begin
      add_run(1'b1, 4);
      add_run(1'b0, 4);
    end
    add_run(1'b1, 8);
    // manchester: one goes out as 01, zero as 10
    for (int i = 0; i < DATA_BITS; i++) begin
      b = held_frame[i / 8][7 - (i % 8)];
      line_bits.push_back(!b);
      line_bits.push_back(b);
    end
    add_run(1'b0, TAIL_ZEROS);
    nbytes = line_bits.size() / 8;
    for (int j = 0; j < nbytes; j++) begin
      for (int k = 0; k < 8; k++) v[7-k] = line_bits[j*8 + k];
      beat.data = v;
      beat.last = (j == nbytes - 1);
      beat.code = carried;
      line_beats_q.push_back(beat);
    end
  endfunction

  task automatic send_cmd(input logic mode, input logic [3:0] btn);
    int gap;
    gap = pick_wait(quiet_cmd);
    @(negedge clk);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_if.valid  <= 1'b1;
    cmd_if.mode   <= mode;
    cmd_if.button <= btn;
    do @(posedge clk); while (!cmd_if.ready);
    encode_transmission(mode, btn);
  endtask

  // stop sending and let every queued beat come out
  task automatic wait_idle();
    @(negedge clk);
    cmd_if.valid <= 1'b0;
    while (line_beats_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input addr_t val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ADDR: remote_addr = val;
      REG_CODE: roll_code = val[15:0];
      REG_KEY:  key_val = val[7:0];
      default: ;
    endcase
  endtask

  // stream side: random stall before each beat
  initial begin
    int n;
    stream_if.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      n = pick_wait(quiet_stream);
      repeat (n) @(negedge clk) stream_if.ready <= 1'b0;
      @(negedge clk) stream_if.ready <= 1'b1;
      do @(posedge clk); while (!(stream_if.valid && stream_if.ready));
    end
  end

  always @(posedge clk) begin
    line_beat_t want;
    if (!rst && stream_if.valid && stream_if.ready) begin
      beats_seen = beats_seen + 1;
      if (line_beats_q.size() == 0) begin
        beat_errs = beat_errs + 1;
        if (beat_errs <= MAX_REPORTS)
          $display("unexpected beat %0d: %02h last %0b code %04h", beats_seen,
                   stream_if.stream_byte, stream_if.last_byte, stream_if.code_used);
      end else begin
        want = line_beats_q.pop_front();
        if (stream_if.stream_byte !== want.data || stream_if.last_byte !== want.last ||
            stream_if.code_used !== want.code) begin
          beat_errs = beat_errs + 1;
          if (beat_errs <= MAX_REPORTS)
            $display("beat %0d: expected %02h/%0b/%04h, got %02h/%0b/%04h",
                     beats_seen, want.data, want.last, want.code, stream_if.stream_byte,
                     stream_if.last_byte, stream_if.code_used);
        end
      end
    end
  end

  // repeat with nothing built yet, then a build with the reset key
  task automatic test_reset_defaults();
    quiet_cmd = 1'b0;
    quiet_stream = 1'b0;
    send_cmd(MODE_REPEAT, 4'hF);
    send_cmd(MODE_REPEAT, 4'h0);
    send_cmd(MODE_BUILD, 4'h5);
    send_cmd(MODE_REPEAT, 4'hA);
    wait_idle();
  endtask

  // all-ones and all-zero registers, buttons at both ends, code wrap
  task automatic test_field_extremes();
    write_reg(REG_ADDR, 24'hFFFFFF);
    write_reg(REG_CODE, 24'hFFFFFE);
    write_reg(REG_KEY, 24'hFFFFFF);
    send_cmd(MODE_BUILD, 4'hF);
    send_cmd(MODE_BUILD, 4'h0);
    send_cmd(MODE_REPEAT, 4'h3);
    send_cmd(MODE_BUILD, 4'hF);
    send_cmd(MODE_REPEAT, 4'hC);
    wait_idle();
    write_reg(REG_ADDR, 24'h000000);
    write_reg(REG_CODE, 24'h000000);
    write_reg(REG_KEY, 24'h000000);
    quiet_cmd = 1'b1;
    quiet_stream = 1'b1;
    send_cmd(MODE_BUILD, 4'h0);
    send_cmd(MODE_REPEAT, 4'hF);
    send_cmd(MODE_BUILD, 4'h9);
    wait_idle();
    quiet_cmd = 1'b0;
    quiet_stream = 1'b0;
  endtask

  // writes to the unused index must change nothing
  task automatic test_unused_index();
    write_reg(REG_ADDR, 24'h5A3C96);
    write_reg(REG_CODE, 24'h00ABCD);
    write_reg(REG_KEY, 24'h0000A7);
    write_reg(REG_UNUSED, 24'hFFFFFF);
    send_cmd(MODE_BUILD, 4'h6);
    send_cmd(MODE_REPEAT, 4'h1);
    wait_idle();
    write_reg(REG_UNUSED, 24'h000000);
    send_cmd(MODE_BUILD, 4'hE);
    wait_idle();
  endtask

  // builds followed by a few repeats, registers reshuffled every phase
  task automatic test_random_traffic();
    int    sent;
    int    next_phase;
    int    reps;
    code_t start;
    sent = 0;
    next_phase = 0;
    while (sent < 240) begin
      if (sent >= next_phase) begin
        wait_idle();
        next_phase = next_phase + 40;
        write_reg(REG_ADDR, addr_t'($urandom));
        start = ($urandom_range(0, 2) == 0) ? code_t'(16'hFFF0 + $urandom_range(0, 15))
                                            : code_t'($urandom);
        write_reg(REG_CODE, {8'($urandom), start});
        write_reg(REG_KEY, addr_t'($urandom));
        if ($urandom_range(0, 1) == 1) write_reg(REG_UNUSED, addr_t'($urandom));
        quiet_cmd = ($urandom_range(0, 3) == 0);
        quiet_stream = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 2) == 0) begin
          send_cmd(MODE_REPEAT, 4'($urandom_range(0, 15)));
          sent++;
        end
      end
      send_cmd(MODE_BUILD, 4'($urandom_range(0, 15)));
      sent++;
      reps = $urandom_range(0, 3);
      repeat (reps) begin
        send_cmd(MODE_REPEAT, 4'($urandom_range(0, 15)));
        sent++;
      end
    end
    wait_idle();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_ADDR;
    cfg_data = '0;
    cmd_if.valid = 1'b0;
    cmd_if.mode = MODE_BUILD;
    cmd_if.button = 4'h0;
    remote_addr = '0;
    roll_code = '0;
    key_val = KEY_RESET;
    for (int i = 0; i < FRAME_LEN; i++) held_frame[i] = 8'h00;
    beat_errs = 0;
    beats_seen = 0;
    quiet_cmd = 1'b0;
    quiet_stream = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_reset_defaults();
    test_field_extremes();
    test_unused_index();
    test_random_traffic();

    repeat (60) @(posedge clk);
    if (beat_errs == 0 && line_beats_q.size() == 0) begin
      $display("rts_remote_frame_encoder_core_tb: done, clean");
    end else begin
      $display("rts_remote_frame_encoder_core_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #16ms;
    $display("rts_remote_frame_encoder_core_tb: done, errors");
    $finish;
  end

endmodule

/* files.f */
sv/rtsenc_pkg.sv
sv/rtsenc_in_if.sv
sv/rtsenc_out_if.sv
sv/rts_remote_frame_encoder_core.sv
test/rts_remote_frame_encoder_core_tb.sv
